/* rtl/mfd_pkg.sv */
package mfd_pkg;

  localparam int MFD_MOTORS = 4;
  localparam int SLOTS_MAX  = 4;
  localparam int SLOT_W     = 2;
  localparam int ID_W       = 11;
  localparam int DATA_W     = 64;
  localparam int COEF_W     = 32;
  localparam int Q_W        = 32;
  localparam int TEMP_W     = 8;
  localparam int ACC_W      = 48;
  localparam int RND_W      = 41;
  localparam int CFG_IDX_W  = 8;
  localparam int PC_W       = 4;

  // register map
  typedef enum logic [2:0] {
    REG_BASE_ID,
    REG_SLOT_OFFSETS,
    REG_ANGLE_SCALE,
    REG_RADPS_SCALE,
    REG_RPM_SCALE,
    REG_CURRENT_SCALE,
    REG_TORQUE_SCALE,
    REG_TURN_SCALE
  } reg_idx_t;

  localparam logic [ID_W-1:0]   RST_BASE_ID       = 11'd512;
  localparam logic [COEF_W-1:0] RST_SLOT_OFFSETS  = 32'h0403_0201;
  localparam logic [COEF_W-1:0] RST_ANGLE_SCALE   = 32'd737280;
  localparam logic [COEF_W-1:0] RST_RADPS_SCALE   = 32'd48803;
  localparam logic [COEF_W-1:0] RST_RPM_SCALE     = 32'd466034;
  localparam logic [COEF_W-1:0] RST_CURRENT_SCALE = 32'd10240;
  localparam logic [COEF_W-1:0] RST_TORQUE_SCALE  = 32'd1843;
  localparam logic [COEF_W-1:0] RST_TURN_SCALE    = 32'd466034;

  // pi/180 in unsigned Q0.32
  localparam logic signed [32:0] DEG_TO_RAD_Q32 = 33'sd74961321;
  localparam logic signed [33:0] HALF_TURN_Q16  = 34'sd11796480;
  localparam logic signed [33:0] FULL_TURN_Q16  = 34'sd23592960;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHECK,
    OP_STEP,
    OP_ACC,
    OP_EMIT,
    OP_NEXT
  } op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ANGLE,
    MUL_RAD,
    MUL_TURN,
    MUL_RADPS,
    MUL_RPM,
    MUL_CUR,
    MUL_TRQ
  } mul_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_DEG,
    WR_RAD,
    WR_RND,
    WR_RADPS,
    WR_RPM,
    WR_CUR,
    WR_TRQ
  } wr_sel_t;

  typedef struct packed {
    op_t             op;
    mul_sel_t        mul;
    wr_sel_t         wr;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] slot;
    ctrl_word_t        word;
  } seq_ctrl_t;

  typedef struct packed {
    logic match;
    logic out_full;
  } seq_stat_t;

  // microprogram addresses
  localparam logic [PC_W-1:0] STEP_CHECK   = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_ANG = 4'd1;
  localparam logic [PC_W-1:0] STEP_WR_DEG  = 4'd2;
  localparam logic [PC_W-1:0] STEP_WRAP    = 4'd3;
  localparam logic [PC_W-1:0] STEP_MUL_TRN = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_RPS = 4'd5;
  localparam logic [PC_W-1:0] STEP_ACC     = 4'd6;
  localparam logic [PC_W-1:0] STEP_MUL_CUR = 4'd7;
  localparam logic [PC_W-1:0] STEP_MUL_TRQ = 4'd8;
  localparam logic [PC_W-1:0] STEP_WR_TRQ  = 4'd9;
  localparam logic [PC_W-1:0] STEP_EMIT    = 4'd10;
  localparam logic [PC_W-1:0] STEP_NEXT    = 4'd11;

  function automatic ctrl_word_t mk_word(input op_t op, input mul_sel_t mul,
                                         input wr_sel_t wr, input logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.op     = op;
    w.mul    = mul;
    w.wr     = wr;
    w.target = target;
    return w;
  endfunction

  // product register is written at the end of a step, so a write step
  // consumes the product issued by the step before it
  function automatic ctrl_word_t mfd_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = mk_word(OP_NOP, MUL_NONE, WR_NONE, STEP_CHECK);
    case (pc)
      STEP_CHECK:   w = mk_word(OP_CHECK, MUL_NONE,  WR_NONE,  STEP_NEXT);
      STEP_MUL_ANG: w = mk_word(OP_NOP,   MUL_ANGLE, WR_NONE,  STEP_CHECK);
      STEP_WR_DEG:  w = mk_word(OP_NOP,   MUL_NONE,  WR_DEG,   STEP_CHECK);
      STEP_WRAP:    w = mk_word(OP_STEP,  MUL_RAD,   WR_NONE,  STEP_CHECK);
      STEP_MUL_TRN: w = mk_word(OP_NOP,   MUL_TURN,  WR_RAD,   STEP_CHECK);
      STEP_MUL_RPS: w = mk_word(OP_NOP,   MUL_RADPS, WR_RND,   STEP_CHECK);
      STEP_ACC:     w = mk_word(OP_ACC,   MUL_RPM,   WR_RADPS, STEP_CHECK);
      STEP_MUL_CUR: w = mk_word(OP_NOP,   MUL_CUR,   WR_RPM,   STEP_CHECK);
      STEP_MUL_TRQ: w = mk_word(OP_NOP,   MUL_TRQ,   WR_CUR,   STEP_CHECK);
      STEP_WR_TRQ:  w = mk_word(OP_NOP,   MUL_NONE,  WR_TRQ,   STEP_CHECK);
      STEP_EMIT:    w = mk_word(OP_EMIT,  MUL_NONE,  WR_NONE,  STEP_CHECK);
      STEP_NEXT:    w = mk_word(OP_NEXT,  MUL_NONE,  WR_NONE,  STEP_CHECK);
      default:      w = mk_word(OP_NOP,   MUL_NONE,  WR_NONE,  STEP_CHECK);
    endcase
    return w;
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

endpackage

/* rtl/mfd_if.sv */
interface mfd_in_if import mfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   frame_id;
  logic [DATA_W-1:0] frame_data;

  modport source(output valid, frame_id, frame_data, input ready);
  modport sink(input valid, frame_id, frame_data, output ready);
endinterface

interface mfd_out_if import mfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SLOT_W-1:0]       motor_slot;
  logic signed [Q_W-1:0]   pos_degrees;
  logic signed [Q_W-1:0]   pos_radians;
  logic signed [Q_W-1:0]   speed_radps;
  logic signed [Q_W-1:0]   speed_rpm;
  logic signed [Q_W-1:0]   current_amp;
  logic signed [Q_W-1:0]   shaft_torque;
  logic [TEMP_W-1:0]       winding_temp;
  logic signed [ACC_W-1:0] total_angle;
  logic                    last_of_run;

  modport source(output valid, motor_slot, pos_degrees, pos_radians, speed_radps, speed_rpm,
                 current_amp, shaft_torque, winding_temp, total_angle, last_of_run,
                 input ready);
  modport sink(input valid, motor_slot, pos_degrees, pos_radians, speed_radps, speed_rpm,
               current_amp, shaft_torque, winding_temp, total_angle, last_of_run,
               output ready);
endinterface

interface mfd_cfg_if import mfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/mfd_seq.sv */
module mfd_seq import mfd_pkg::*; #(
  parameter int MOTORS = MFD_MOTORS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  seq_stat_t stat,
  output seq_ctrl_t ctrl
);

  logic              busy_r, busy_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  ctrl_word_t        word;

  assign word = mfd_rom(pc_r);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    slot_nxt = slot_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = STEP_CHECK;
        slot_nxt = '0;
      end
    end else begin
      unique case (word.op)
        OP_CHECK: pc_nxt = stat.match ? pc_r + 4'd1 : word.target;
        OP_EMIT:  pc_nxt = stat.out_full ? pc_r : pc_r + 4'd1;
        OP_NEXT: begin
          if (slot_r == SLOT_W'(MOTORS - 1)) begin
            busy_nxt = 1'b0;
            pc_nxt   = STEP_CHECK;
          end else begin
            slot_nxt = slot_r + 2'd1;
            pc_nxt   = word.target;
          end
        end
        default:  pc_nxt = pc_r + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= STEP_CHECK;
      slot_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign ctrl.active = busy_r;
  assign ctrl.slot   = slot_r;
  assign ctrl.word   = word;

endmodule

/* rtl/motor_feedback_decoder.sv */
// each matching slot's result is registered at its emit step, after the lower slots are walked
// each slot walks a 12-step microprogram when it matches, 2 steps when it does not;
// one 33x33 multiplier is shared by the six scalings and the turn step
// no new frame is taken until the walk over all slots ends; a stalled result holds the walk
// synchronous active-low reset loads the register defaults and clears the
// per-slot previous and accumulated angles
module motor_feedback_decoder import mfd_pkg::*; #(
  parameter int MOTORS = MFD_MOTORS
) (
  input logic      clk,
  input logic      rst_n,
  mfd_in_if.sink   in_if,
  mfd_out_if.source out_if,
  mfd_cfg_if.sink  cfg_if
);

  seq_ctrl_t ctrl;
  seq_stat_t stat;
  logic      start;

  // configuration
  logic [ID_W-1:0]   base_id_r;
  logic [COEF_W-1:0] slot_offsets_r, angle_scale_r, radps_scale_r, rpm_scale_r;
  logic [COEF_W-1:0] current_scale_r, torque_scale_r, turn_scale_r;

  // frame
  logic [SLOTS_MAX-1:0] match_r, match_nxt;
  logic signed [15:0]   raw_angle_r, raw_speed_r, raw_cur_r;
  logic [TEMP_W-1:0]    temp_r;
  logic [ID_W:0]        tgt [SLOTS_MAX];

  // datapath
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod_full;
  logic signed [63:0]      prod_r;
  logic signed [64:0]      prod_ext, rshifted;
  logic signed [Q_W-1:0]   wr_val;
  logic signed [Q_W-1:0]   deg_r, rad_r, step_r, radps_r, rpm_r, cur_r, trq_r;
  logic signed [RND_W-1:0] rnd_r;
  logic signed [32:0]      diff;
  logic signed [33:0]      wrapped;
  logic signed [Q_W-1:0]   step_nxt;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [Q_W-1:0]   prev_r [SLOTS_MAX];
  logic signed [ACC_W-1:0] acc_r [SLOTS_MAX];
  logic                    last;

  // result register
  logic                    out_valid_r;
  logic [SLOT_W-1:0]       o_slot_r;
  logic signed [Q_W-1:0]   o_deg_r, o_rad_r, o_radps_r, o_rpm_r, o_cur_r, o_trq_r;
  logic [TEMP_W-1:0]       o_temp_r;
  logic signed [ACC_W-1:0] o_total_r;
  logic                    o_last_r;
  logic                    fire_emit;

  assign start        = in_if.valid & in_if.ready;
  assign in_if.ready  = ~ctrl.active;
  assign cfg_if.ready = 1'b1;

  assign stat.match    = match_r[ctrl.slot];
  assign stat.out_full = out_valid_r & ~out_if.ready;

  mfd_seq #(.MOTORS(MOTORS)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r       <= RST_BASE_ID;
      slot_offsets_r  <= RST_SLOT_OFFSETS;
      angle_scale_r   <= RST_ANGLE_SCALE;
      radps_scale_r   <= RST_RADPS_SCALE;
      rpm_scale_r     <= RST_RPM_SCALE;
      current_scale_r <= RST_CURRENT_SCALE;
      torque_scale_r  <= RST_TORQUE_SCALE;
      turn_scale_r    <= RST_TURN_SCALE;
    end else if (cfg_if.valid && cfg_if.index[CFG_IDX_W-1:3] == '0) begin
      unique case (reg_idx_t'(cfg_if.index[2:0]))
        REG_BASE_ID:       base_id_r       <= cfg_if.data[ID_W-1:0];
        REG_SLOT_OFFSETS:  slot_offsets_r  <= cfg_if.data;
        REG_ANGLE_SCALE:   angle_scale_r   <= cfg_if.data;
        REG_RADPS_SCALE:   radps_scale_r   <= cfg_if.data;
        REG_RPM_SCALE:     rpm_scale_r     <= cfg_if.data;
        REG_CURRENT_SCALE: current_scale_r <= cfg_if.data;
        REG_TORQUE_SCALE:  torque_scale_r  <= cfg_if.data;
        REG_TURN_SCALE:    turn_scale_r    <= cfg_if.data;
      endcase
    end
  end

  // identifier sum is one bit wider so it never wraps
  always_comb begin
    for (int j = 0; j < SLOTS_MAX; j++) begin
      tgt[j]       = {1'b0, base_id_r} + {4'b0, slot_offsets_r[8*j +: 8]};
      match_nxt[j] = (j < MOTORS) && (tgt[j] == {1'b0, in_if.frame_id});
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      match_r     <= match_nxt;
      raw_angle_r <= in_if.frame_data[63:48];
      raw_speed_r <= in_if.frame_data[47:32];
      raw_cur_r   <= in_if.frame_data[31:16];
      temp_r      <= in_if.frame_data[15:8];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = {{17{raw_angle_r[15]}}, raw_angle_r};
    mul_b = {1'b0, angle_scale_r};
    unique case (ctrl.word.mul)
      MUL_RAD: begin
        mul_a = {deg_r[31], deg_r};
        mul_b = DEG_TO_RAD_Q32;
      end
      MUL_TURN: begin
        mul_a = {step_r[31], step_r};
        mul_b = {1'b0, turn_scale_r};
      end
      MUL_RADPS: begin
        mul_a = {{17{raw_speed_r[15]}}, raw_speed_r};
        mul_b = {1'b0, radps_scale_r};
      end
      MUL_RPM: begin
        mul_a = {{17{raw_speed_r[15]}}, raw_speed_r};
        mul_b = {1'b0, rpm_scale_r};
      end
      MUL_CUR: begin
        mul_a = {{17{raw_cur_r[15]}}, raw_cur_r};
        mul_b = {1'b0, current_scale_r};
      end
      MUL_TRQ: begin
        mul_a = {{17{raw_cur_r[15]}}, raw_cur_r};
        mul_b = {1'b0, torque_scale_r};
      end
      default: begin
        mul_a = {{17{raw_angle_r[15]}}, raw_angle_r};
        mul_b = {1'b0, angle_scale_r};
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.active && ctrl.word.mul != MUL_NONE) begin
      prod_r <= prod_full[63:0];
    end
  end

  // round half up, then drop fraction bits
  assign prod_ext = {prod_r[63], prod_r};

  always_comb begin
    case (ctrl.word.wr)
      WR_RAD:  rshifted = (prod_ext + (65'sd1 <<< 31)) >>> 32;
      WR_RND:  rshifted = (prod_ext + (65'sd1 <<< 23)) >>> 24;
      default: rshifted = (prod_ext + (65'sd1 <<< 7)) >>> 8;
    endcase
  end

  assign wr_val = sat32(rshifted);

  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      case (ctrl.word.wr)
        WR_DEG:   deg_r   <= wr_val;
        WR_RAD:   rad_r   <= wr_val;
        WR_RND:   rnd_r   <= rshifted[RND_W-1:0];
        WR_RADPS: radps_r <= wr_val;
        WR_RPM:   rpm_r   <= wr_val;
        WR_CUR:   cur_r   <= wr_val;
        WR_TRQ:   trq_r   <= wr_val;
        default:  ;
      endcase
    end
  end

  // a jump of more than half a turn is a wrap
  always_comb begin
    diff = {deg_r[31], deg_r} - {prev_r[ctrl.slot][31], prev_r[ctrl.slot]};
    if ($signed({diff[32], diff}) < -HALF_TURN_Q16) begin
      wrapped = {diff[32], diff} + FULL_TURN_Q16;
    end else if ($signed({diff[32], diff}) > HALF_TURN_Q16) begin
      wrapped = {diff[32], diff} - FULL_TURN_Q16;
    end else begin
      wrapped = {diff[32], diff};
    end
    step_nxt = sat32({{31{wrapped[33]}}, wrapped});
  end

  always_ff @(posedge clk) begin
    if (ctrl.active && ctrl.word.op == OP_STEP) begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    acc_sum = {acc_r[ctrl.slot][ACC_W-1], acc_r[ctrl.slot]}
            + {{(ACC_W + 1 - RND_W){rnd_r[RND_W-1]}}, rnd_r};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SLOTS_MAX; j++) begin
        prev_r[j] <= '0;
        acc_r[j]  <= '0;
      end
    end else if (ctrl.active && ctrl.word.op == OP_ACC) begin
      prev_r[ctrl.slot] <= deg_r;
      acc_r[ctrl.slot]  <= acc_nxt;
    end
  end

  // last result when no higher slot matches
  always_comb begin
    last = 1'b1;
    for (int j = 0; j < SLOTS_MAX; j++) begin
      if (j > int'(ctrl.slot) && match_r[j]) begin
        last = 1'b0;
      end
    end
  end

  assign fire_emit = ctrl.active && ctrl.word.op == OP_EMIT && !stat.out_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_emit) begin
      o_slot_r  <= ctrl.slot;
      o_deg_r   <= deg_r;
      o_rad_r   <= rad_r;
      o_radps_r <= radps_r;
      o_rpm_r   <= rpm_r;
      o_cur_r   <= cur_r;
      o_trq_r   <= trq_r;
      o_temp_r  <= temp_r;
      o_total_r <= acc_r[ctrl.slot];
      o_last_r  <= last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.motor_slot   = o_slot_r;
  assign out_if.pos_degrees  = o_deg_r;
  assign out_if.pos_radians  = o_rad_r;
  assign out_if.speed_radps  = o_radps_r;
  assign out_if.speed_rpm    = o_rpm_r;
  assign out_if.current_amp  = o_cur_r;
  assign out_if.shaft_torque = o_trq_r;
  assign out_if.winding_temp = o_temp_r;
  assign out_if.total_angle  = o_total_r;
  assign out_if.last_of_run  = o_last_r;

endmodule

/* rtl/mfd_checker.sv */
module mfd_checker import mfd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_motor_slot,
  input logic [ACC_W-1:0]  out_total_angle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_motor_slot) && $stable(out_total_angle))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("frame taken while previous one is being decoded");

  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("decoder left idle without a frame");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear control state");

endmodule

bind motor_feedback_decoder mfd_checker u_mfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_motor_slot  (out_if.motor_slot),
  .out_total_angle (out_if.total_angle)
);

/* test/motor_feedback_decoder_tb.sv */
module motor_feedback_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfd_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_FRAMES = 30;
  localparam int SWEEP_FRAMES = 12;
  localparam int DESCENT_RAW = 181;
  localparam logic [COEF_W-1:0] ALL_ONES = '1;
  localparam longint Q_TOP = (longint'(1) <<< (Q_W - 1)) - 1;
  localparam longint Q_BOTTOM = -(longint'(1) <<< (Q_W - 1));
  localparam longint ACC_TOP = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM = -(longint'(1) <<< (ACC_W - 1));

  typedef struct {
    logic [SLOT_W-1:0]       slot;
    logic signed [Q_W-1:0]   deg;
    logic signed [Q_W-1:0]   rad;
    logic signed [Q_W-1:0]   radps;
    logic signed [Q_W-1:0]   rpm;
    logic signed [Q_W-1:0]   amp;
    logic signed [Q_W-1:0]   nm;
    logic [TEMP_W-1:0]       temp;
    logic signed [ACC_W-1:0] total;
    logic                    last;
  } reading_t;

  class decode_tracker;
    logic [ID_W-1:0]       base_id;
    logic [COEF_W-1:0]     offsets;
    logic [COEF_W-1:0]     angle_k;
    logic [COEF_W-1:0]     radps_k;
    logic [COEF_W-1:0]     rpm_k;
    logic [COEF_W-1:0]     amp_k;
    logic [COEF_W-1:0]     nm_k;
    logic [COEF_W-1:0]     turn_k;
    logic signed [Q_W-1:0] prev_deg [SLOTS_MAX];
    longint                turns [SLOTS_MAX];
    reading_t              pending [$];
    int                    errors;

    function new();
      base_id = RST_BASE_ID;
      offsets = RST_SLOT_OFFSETS;
      angle_k = RST_ANGLE_SCALE;
      radps_k = RST_RADPS_SCALE;
      rpm_k = RST_RPM_SCALE;
      amp_k = RST_CURRENT_SCALE;
      nm_k = RST_TORQUE_SCALE;
      turn_k = RST_TURN_SCALE;
      for (int k = 0; k < SLOTS_MAX; k++) begin
        prev_deg[k] = '0;
        turns[k] = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        REG_BASE_ID: begin
          base_id = val[ID_W-1:0];
        end
        REG_SLOT_OFFSETS:  offsets = val;
        REG_ANGLE_SCALE:   angle_k = val;
        REG_RADPS_SCALE:   radps_k = val;
        REG_RPM_SCALE:     rpm_k = val;
        REG_CURRENT_SCALE: amp_k = val;
        REG_TORQUE_SCALE:  nm_k = val;
        REG_TURN_SCALE:    turn_k = val;
        default: ;
      endcase
    endfunction

    // round half up: add half an lsb, then arithmetic shift
    static function longint round_shift(longint p, int s);
      return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function logic signed [Q_W-1:0] clamp32(longint v);
      if (v > Q_TOP) begin
        return Q_TOP[Q_W-1:0];
      end else if (v < Q_BOTTOM) begin
        return Q_BOTTOM[Q_W-1:0];
      end
      return v[Q_W-1:0];
    endfunction

    static function logic signed [Q_W-1:0] scale_raw(logic signed [15:0] raw,
                                                     logic [COEF_W-1:0] coef);
      return clamp32(round_shift(longint'(raw) * longint'(coef), 8));
    endfunction

    function int decode_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
      logic signed [15:0] raw_ang;
      logic signed [15:0] raw_spd;
      logic signed [15:0] raw_cur;
      reading_t           r;
      reading_t           held;
      bit                 have_held;
      int                 hits;
      int                 target;
      longint             diff;
      longint             step;
      longint             acc;
      raw_ang = data[63:48];
      raw_spd = data[47:32];
      raw_cur = data[31:16];
      hits = 0;
      have_held = 1'b0;
      for (int k = 0; k < MFD_MOTORS; k++) begin
        // sum is not wrapped to 11 bits, so it can miss every id
        target = int'(base_id) + int'(offsets[8*k +: 8]);
        if (target != int'(id)) continue;
        r.slot = SLOT_W'(k);
        r.deg = scale_raw(raw_ang, angle_k);
        r.rad = clamp32(round_shift(longint'(r.deg) * longint'(DEG_TO_RAD_Q32), 32));
        r.radps = scale_raw(raw_spd, radps_k);
        r.rpm = scale_raw(raw_spd, rpm_k);
        r.amp = scale_raw(raw_cur, amp_k);
        r.nm = scale_raw(raw_cur, nm_k);
        r.temp = data[15:8];
        diff = longint'(r.deg) - longint'(prev_deg[k]);
        if (diff < -longint'(HALF_TURN_Q16)) begin
          step = diff + longint'(FULL_TURN_Q16);
        end else if (diff > longint'(HALF_TURN_Q16)) begin
          step = diff - longint'(FULL_TURN_Q16);
        end else begin
          step = diff;
        end
        step = longint'(clamp32(step));
        acc = turns[k] + round_shift(step * longint'(turn_k), 24);
        if (acc > ACC_TOP) acc = ACC_TOP;
        if (acc < ACC_BOTTOM) acc = ACC_BOTTOM;
        turns[k] = acc;
        prev_deg[k] = r.deg;
        r.total = acc[ACC_W-1:0];
        r.last = 1'b0;
        if (have_held) pending.push_back(held);
        held = r;
        have_held = 1'b1;
        hits++;
      end
      if (have_held) begin
        held.last = 1'b1;
        pending.push_back(held);
      end
      return hits;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result for slot %0d", $time, got.slot);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("motor_slot", want.slot, got.slot);
      compare_field("pos_degrees", want.deg, got.deg);
      compare_field("pos_radians", want.rad, got.rad);
      compare_field("speed_radps", want.radps, got.radps);
      compare_field("speed_rpm", want.rpm, got.rpm);
      compare_field("current_amp", want.amp, got.amp);
      compare_field("shaft_torque", want.nm, got.nm);
      compare_field("winding_temp", want.temp, got.temp);
      compare_field("total_angle", want.total, got.total);
      compare_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mfd_in_if  in_bus ();
  mfd_out_if out_bus ();
  mfd_cfg_if cfg_bus ();

  motor_feedback_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  decode_tracker   tracker;
  int              in_idle_pct;
  int              out_stall_pct;
  int              quiet_cycles;
  logic [15:0]     recent_angle;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    reading_t got;
    if (rst_n === 1'b1) begin
      if (out_bus.valid && out_bus.ready) begin
        got.slot = out_bus.motor_slot;
        got.deg = out_bus.pos_degrees;
        got.rad = out_bus.pos_radians;
        got.radps = out_bus.speed_radps;
        got.rpm = out_bus.speed_rpm;
        got.amp = out_bus.current_amp;
        got.nm = out_bus.shaft_torque;
        got.temp = out_bus.winding_temp;
        got.total = out_bus.total_angle;
        got.last = out_bus.last_of_run;
        tracker.check_reading(got);
      end
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int slot_id(int k);
    return int'(tracker.base_id) + int'(tracker.offsets[8*k +: 8]);
  endfunction

  // every task starts and ends just after a falling edge
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    tracker.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [COEF_W-1:0] vals [8]);
    reg_idx_t r;
    r = r.first();
    do begin
      set_reg(CFG_IDX_W'(r), vals[int'(r)]);
      r = r.next();
    end while (r != r.first());
    // a write past the register map has to be dropped
    set_reg(CFG_IDX_W'($urandom_range(int'(REG_TURN_SCALE) + 1, (1 << CFG_IDX_W) - 1)),
            $urandom);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] data,
                            output int hits);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.frame_id <= id;
    in_bus.frame_data <= data;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    hits = tracker.decode_frame(id, data);
    @(negedge clk);
  endtask

  // a frame with no match can still be in flight once the queue is empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_scale();
    case ($urandom_range(4))
      0: return '0;
      1: return ALL_ONES;
      2: return $urandom;
      default: return $urandom_range(0, 1 << 24);
    endcase
  endfunction

  task automatic random_phase(input int idle_pct, input int stall_pct);
    logic [COEF_W-1:0] vals [8];
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    int                counted;
    int                hits;
    int                k;
    int                base;
    case ($urandom_range(3))
      0: base = 0;
      1: base = 1792;
      default: base = $urandom_range(0, 1792);
    endcase
    vals[0] = $urandom;
    vals[0][ID_W-1:0] = ID_W'(base);
    vals[1] = $urandom;
    if ($urandom_range(2) == 0) vals[1][23:16] = vals[1][7:0];
    for (int i = 2; i < 8; i++) vals[i] = pick_scale();
    load_settings(vals);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    counted = 0;
    while (counted < RANDOM_FRAMES) begin
      k = $urandom_range(MFD_MOTORS - 1);
      id = ($urandom_range(9) < 8) ? ID_W'(slot_id(k)) : ID_W'($urandom);
      data = {$urandom, $urandom};
      // keep some steps short so the turn counter moves without wrapping
      if ($urandom_range(1)) data[63:48] = recent_angle + 16'($urandom_range(0, 4000)) - 16'd2000;
      recent_angle = data[63:48];
      send_frame(id, data, hits);
      if (hits > 0) counted++;
    end
    settle();
  endtask

  // descending by 181 degrees yields +179 per frame, the jump back up a saturated step
  task automatic saturate_turns();
    logic [COEF_W-1:0] vals [8];
    int                hits;
    int                raw;
    vals = '{32'd100, 32'h0302_0100, 32'(DESCENT_RAW) << 24, $urandom, $urandom,
             $urandom, $urandom, ALL_ONES};
    load_settings(vals);
    in_idle_pct = 0;
    out_stall_pct = 0;
    raw = -DESCENT_RAW;
    for (int n = 0; n < SWEEP_FRAMES; n++) begin
      send_frame(ID_W'(slot_id(0)), {16'(raw), $urandom, 16'($urandom)}, hits);
      raw = (raw == -DESCENT_RAW) ? DESCENT_RAW : raw - 1;
    end
    settle();
  endtask

  initial begin
    logic [COEF_W-1:0] vals [8];
    int                hits;
    tracker = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.frame_id = '0;
    in_bus.frame_data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    quiet_cycles = 0;
    recent_angle = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults: one slot per frame, field extremes, wraps both ways
    send_frame(ID_W'(slot_id(0)), '0, hits);
    send_frame(ID_W'(slot_id(1)), '1, hits);
    send_frame(ID_W'(slot_id(2)), 64'h7FFF_7FFF_7FFF_FF00, hits);
    send_frame(ID_W'(slot_id(3)), 64'h8000_8000_8000_00FF, hits);
    send_frame(ID_W'(slot_id(0)), 64'h7FFF_1234_5678_9ABC, hits);
    send_frame(ID_W'(slot_id(0)), 64'h8000_0001_FFFF_0000, hits);
    send_frame(ID_W'(slot_id(0)), 64'h8010_FFFF_0001_7F00, hits);
    send_frame(tracker.base_id, {$urandom, $urandom}, hits);
    send_frame('0, '1, hits);
    send_frame('1, '0, hits);
    settle();

    // top id with shared slots, one sum past the id range, saturating scales
    vals = '{ALL_ONES, 32'h0000_0100, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
             ALL_ONES, ALL_ONES};
    load_settings(vals);
    send_frame('1, 64'h7FFF_7FFF_7FFF_AA55, hits);
    send_frame('1, 64'h8000_8000_8000_55AA, hits);
    send_frame('1, 64'h0001_FFFF_0001_0000, hits);
    send_frame('0, '1, hits);
    settle();

    // every slot on id zero, zero scales
    vals = '{'0, '0, '0, '0, '0, '0, '0, '0};
    load_settings(vals);
    send_frame('0, {$urandom, $urandom}, hits);
    send_frame('0, '1, hits);
    send_frame(ID_W'(1), '0, hits);
    settle();

    random_phase(0, 0);
    random_phase(72, 0);
    random_phase(0, 72);
    random_phase(15, 15);
    random_phase($urandom_range(0, 50), $urandom_range(0, 50));
    saturate_turns();

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
